@@ src/uer_pkg.sv @@
// Shared types and constants of the ultrasonic echo ranger.
`timescale 1ns / 1ps

package uer_pkg;

  // Counter width of the tick and pulse counters.
  localparam int COUNT_WIDTH = 16;

  // Field widths of the channels.
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 4;
  localparam int PULSE_W   = 16;
  localparam int DIST_W    = 14;
  localparam int STATUS_W  = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_RISE_TIMEOUT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FALL_TIMEOUT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE    = CFG_IDX_W'(3);

  // Register values after reset.
  localparam logic [CFG_W-1:0] RISE_TIMEOUT_RST = CFG_W'(30000);
  localparam logic [CFG_W-1:0] FALL_TIMEOUT_RST = CFG_W'(30000);
  localparam logic [CFG_W-1:0] MIN_PULSE_RST    = CFG_W'(100);
  localparam logic [CFG_W-1:0] MAX_PULSE_RST    = CFG_W'(25000);

  // Trigger sequence lengths in ticks.
  localparam int PRE_LOW_TICKS   = 2;
  localparam int TRIG_HIGH_TICKS = 10;

  // Distance is (pulse * 343 + 1000) / 2000, tracked as quotient and remainder.
  localparam int DIST_STEP  = 343;
  localparam int DIST_ROUND = 1000;
  localparam int DIST_DEN   = 2000;
  localparam int REM_W      = $clog2(DIST_DEN);

  // Measurement status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] ST_NO_RISE   = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] ST_STUCK     = STATUS_W'(2);
  localparam logic [STATUS_W-1:0] ST_OUT_RANGE = STATUS_W'(3);

  // One result word.
  typedef struct packed {
    logic                trig_level;
    logic                busy_res;
    logic                done_res;
    logic [STATUS_W-1:0] status;
    logic [PULSE_W-1:0]  echo_ticks;
    logic [DIST_W-1:0]   dist_mm;
  } res_t;

endpackage

@@ src/uer_if.sv @@
// Handshake channel interfaces of the ultrasonic echo ranger.
`timescale 1ns / 1ps

// Tick channel: one word per microsecond tick.
interface uer_tick_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo_level;

  modport source (output valid, output start_req, output echo_level, input ready);
  modport sink (input valid, input start_req, input echo_level, output ready);
endinterface

// Result channel: one word per accepted tick.
interface uer_res_if;
  logic                          valid;
  logic                          ready;
  logic                          trig_level;
  logic                          busy_res;
  logic                          done_res;
  logic [uer_pkg::STATUS_W-1:0]  status;
  logic [uer_pkg::PULSE_W-1:0]   echo_ticks;
  logic [uer_pkg::DIST_W-1:0]    dist_mm;

  modport source (output valid, output trig_level, output busy_res, output done_res,
                  output status, output echo_ticks, output dist_mm, input ready);
  modport sink (input valid, input trig_level, input busy_res, input done_res,
                input status, input echo_ticks, input dist_mm, output ready);
endinterface

// Configuration write channel.
interface uer_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [uer_pkg::CFG_IDX_W-1:0] index;
  logic [uer_pkg::CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/ultrasonic_echo_ranger_top.sv @@
// Top level of the ultrasonic echo ranger: trigger sequencer, echo timer and distance.
`timescale 1ns / 1ps

// Usage
// - tick: one word per microsecond, carrying start_req and the sampled echo level.
//   A start request from idle holds the trigger low for 2 ticks, high for 10, then
//   waits for the echo to rise and times its high pulse.
// - res: exactly one word per accepted tick, in order. The finishing tick of a
//   measurement has done_res set, with status, echo_ticks and dist_mm.
// - cfg: register writes (0 rise timeout, 1 fall timeout, 2 min pulse, 3 max pulse),
//   always ready; other indexes are ignored. The user must write only while no tick
//   is in flight; the block does not enforce it.
// Throughput, reset and stalls
// - Each accepted tick's result word is registered before it shows on res. One tick
//   per cycle is sustained while res does not stall.
// - The distance divide by 2000 is a running quotient and remainder that follow the
//   pulse counter, so the whole step is one add and compare per accepted tick.
// - rst (synchronous) returns to idle, empties the result stage and restores the
//   register defaults.
// - A result register plus one skid word part the sides: while res stalls, one more
//   tick is still taken, then tick.ready drops until res accepts a word.
module ultrasonic_echo_ranger_top (
  input  logic       clk,
  input  logic       rst,
  uer_tick_if.sink   tick,
  uer_res_if.source  res,
  uer_cfg_if.sink    cfg
);
  import uer_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PRE_LOW,
    PH_TRIG_HIGH,
    PH_WAIT_RISE,
    PH_MEASURE
  } phase_t;

  // Configuration registers.
  logic [CFG_W-1:0] rise_timeout;
  logic [CFG_W-1:0] fall_timeout;
  logic [CFG_W-1:0] min_pulse;
  logic [CFG_W-1:0] max_pulse;

  // Measurement state.
  phase_t                 phase;
  phase_t                 phase_next;
  logic [COUNT_WIDTH-1:0] tick_count;
  logic [COUNT_WIDTH-1:0] tick_count_next;
  logic [COUNT_WIDTH-1:0] pulse_count;
  logic [COUNT_WIDTH-1:0] pulse_count_next;
  logic [DIST_W-1:0]      dist_quo;
  logic [DIST_W-1:0]      dist_quo_next;
  logic [REM_W-1:0]       dist_rem;
  logic [REM_W-1:0]       dist_rem_next;

  // Result stage and skid word.
  res_t res_word;
  res_t res_reg;
  logic res_valid;
  res_t skid_reg;
  logic skid_valid;

  logic                   push;
  logic                   pop;
  logic [COUNT_WIDTH-1:0] tick_inc;
  logic [COUNT_WIDTH-1:0] pulse_inc;
  logic [REM_W:0]         rem_sum;
  logic [REM_W-1:0]       rem_step;
  logic [DIST_W-1:0]      quo_step;
  logic                   out_of_range;

  assign push = tick.valid && tick.ready;
  assign pop  = res.valid && res.ready;

  assign tick.ready = !skid_valid;
  assign cfg.ready  = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      rise_timeout <= RISE_TIMEOUT_RST;
      fall_timeout <= FALL_TIMEOUT_RST;
      min_pulse    <= MIN_PULSE_RST;
      max_pulse    <= MAX_PULSE_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_RISE_TIMEOUT: rise_timeout <= cfg.data;
        REG_FALL_TIMEOUT: fall_timeout <= cfg.data;
        REG_MIN_PULSE:    min_pulse    <= cfg.data;
        REG_MAX_PULSE:    max_pulse    <= cfg.data;
        default: ;
      endcase
    end
  end

  // Counter increments and the running distance division step.
  assign tick_inc  = tick_count + COUNT_WIDTH'(1);
  assign pulse_inc = pulse_count + COUNT_WIDTH'(1);
  assign rem_sum   = {1'b0, dist_rem} + (REM_W+1)'(DIST_STEP);

  always_comb begin
    if (rem_sum >= (REM_W+1)'(DIST_DEN)) begin
      rem_step = REM_W'(rem_sum - (REM_W+1)'(DIST_DEN));
      quo_step = dist_quo + DIST_W'(1);
    end else begin
      rem_step = REM_W'(rem_sum);
      quo_step = dist_quo;
    end
  end

  assign out_of_range = (pulse_inc < COUNT_WIDTH'(min_pulse)) ||
                        (pulse_inc > COUNT_WIDTH'(max_pulse));

  // Next state and result word for the tick on the input.
  always_comb begin
    phase_next       = phase;
    tick_count_next  = tick_count;
    pulse_count_next = pulse_count;
    dist_quo_next    = dist_quo;
    dist_rem_next    = dist_rem;
    res_word         = '0;
    case (phase)
      PH_IDLE: begin
        if (tick.start_req) begin
          phase_next       = PH_PRE_LOW;
          tick_count_next  = COUNT_WIDTH'(1);
          pulse_count_next = '0;
          res_word.busy_res = 1'b1;
        end
      end
      PH_PRE_LOW: begin
        tick_count_next = tick_inc;
        if (tick_inc >= COUNT_WIDTH'(PRE_LOW_TICKS)) begin
          phase_next      = PH_TRIG_HIGH;
          tick_count_next = '0;
        end
        res_word.busy_res = 1'b1;
      end
      PH_TRIG_HIGH: begin
        tick_count_next = tick_inc;
        if (tick_inc >= COUNT_WIDTH'(TRIG_HIGH_TICKS)) begin
          phase_next      = PH_WAIT_RISE;
          tick_count_next = '0;
        end
        res_word.trig_level = 1'b1;
        res_word.busy_res   = 1'b1;
      end
      PH_WAIT_RISE: begin
        if (tick.echo_level) begin
          phase_next        = PH_MEASURE;
          pulse_count_next  = '0;
          dist_quo_next     = '0;
          dist_rem_next     = REM_W'(DIST_ROUND);
          res_word.busy_res = 1'b1;
        end else begin
          tick_count_next = tick_inc;
          if (tick_inc >= COUNT_WIDTH'(rise_timeout)) begin
            phase_next        = PH_IDLE;
            tick_count_next   = '0;
            res_word.done_res = 1'b1;
            res_word.status   = ST_NO_RISE;
          end else begin
            res_word.busy_res = 1'b1;
          end
        end
      end
      PH_MEASURE: begin
        pulse_count_next = pulse_inc;
        dist_quo_next    = quo_step;
        dist_rem_next    = rem_step;
        if (!tick.echo_level) begin
          // Echo fell: check the pulse against the accepted window.
          phase_next          = PH_IDLE;
          tick_count_next     = '0;
          res_word.done_res   = 1'b1;
          res_word.echo_ticks = PULSE_W'(pulse_inc);
          if (out_of_range) begin
            res_word.status = ST_OUT_RANGE;
          end else begin
            res_word.status  = ST_OK;
            res_word.dist_mm = quo_step;
          end
        end else if (pulse_inc >= COUNT_WIDTH'(fall_timeout)) begin
          phase_next          = PH_IDLE;
          tick_count_next     = '0;
          res_word.done_res   = 1'b1;
          res_word.status     = ST_STUCK;
          res_word.echo_ticks = PULSE_W'(pulse_inc);
        end else begin
          res_word.busy_res = 1'b1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  // Measurement state advances once per accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      tick_count  <= '0;
      pulse_count <= '0;
    end else if (push) begin
      phase       <= phase_next;
      tick_count  <= tick_count_next;
      pulse_count <= pulse_count_next;
    end
  end

  // Running quotient and remainder of the distance.
  always_ff @(posedge clk) begin
    if (push) begin
      dist_quo <= dist_quo_next;
      dist_rem <= dist_rem_next;
    end
  end

  // Result register with one skid word behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        res_reg    <= skid_reg;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!res_valid || pop) begin
        res_reg   <= res_word;
        res_valid <= 1'b1;
      end else begin
        skid_reg   <= res_word;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  assign res.valid      = res_valid;
  assign res.trig_level = res_reg.trig_level;
  assign res.busy_res   = res_reg.busy_res;
  assign res.done_res   = res_reg.done_res;
  assign res.status     = res_reg.status;
  assign res.echo_ticks = res_reg.echo_ticks;
  assign res.dist_mm    = res_reg.dist_mm;

endmodule

@@ sim/tb.sv @@
// Testbench of the ultrasonic echo ranger: directed and random tick streams checked word by word.
`timescale 1ns / 1ps

module tb;
  import uer_pkg::*;

  // Measurement phases of the ranger as seen from its tick stream.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PRE_LOW,
    PH_TRIG_HIGH,
    PH_WAIT_RISE,
    PH_MEASURE
  } ranger_phase_t;

  localparam int FIRST_UNUSED_REG = int'(REG_MAX_PULSE) + 1;
  localparam int LAST_REG_INDEX   = 2 ** CFG_IDX_W - 1;
  localparam int TRIGGER_TICKS    = PRE_LOW_TICKS + TRIG_HIGH_TICKS;
  localparam int HOLD_CYCLES      = 60;
  localparam int QUIET_LIMIT      = 2000;
  localparam int DRAIN_CYCLES     = 4;
  localparam int END_CYCLES       = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  uer_tick_if tick_ch ();
  uer_res_if  res_ch ();
  uer_cfg_if  cfg_ch ();

  ultrasonic_echo_ranger_top u_top (
    .clk (clk),
    .rst (rst),
    .tick(tick_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  // Predicted ranger state and registers, starting from the reset values.
  ranger_phase_t          rng_phase     = PH_IDLE;
  logic [COUNT_WIDTH-1:0] rng_ticks     = '0;
  logic [COUNT_WIDTH-1:0] rng_pulse     = '0;
  logic [CFG_W-1:0]       cfg_rise_to   = RISE_TIMEOUT_RST;
  logic [CFG_W-1:0]       cfg_fall_to   = FALL_TIMEOUT_RST;
  logic [CFG_W-1:0]       cfg_min_pulse = MIN_PULSE_RST;
  logic [CFG_W-1:0]       cfg_max_pulse = MAX_PULSE_RST;

  res_t        pending_words[$];
  int unsigned fail_count   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned items_sent   = 0;
  bit          calm         = 1'b0;
  bit          hold_req     = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  // Result word that one accepted tick should produce; advances the predicted state.
  function automatic res_t next_ranger_word(input logic start, input logic echo);
    res_t w;
    w = '0;
    case (rng_phase)
      PH_PRE_LOW: begin
        rng_ticks = rng_ticks + 1'b1;
        if (rng_ticks >= PRE_LOW_TICKS) begin
          rng_phase = PH_TRIG_HIGH;
          rng_ticks = '0;
        end
        w.busy_res = 1'b1;
      end
      PH_TRIG_HIGH: begin
        rng_ticks = rng_ticks + 1'b1;
        if (rng_ticks >= TRIG_HIGH_TICKS) begin
          rng_phase = PH_WAIT_RISE;
          rng_ticks = '0;
        end
        w.trig_level = 1'b1;
        w.busy_res   = 1'b1;
      end
      PH_WAIT_RISE: begin
        // Echo level wins over the timeout on the same tick.
        if (echo) begin
          rng_phase  = PH_MEASURE;
          rng_pulse  = '0;
          w.busy_res = 1'b1;
        end else begin
          rng_ticks = rng_ticks + 1'b1;
          if (rng_ticks >= cfg_rise_to) begin
            rng_phase = PH_IDLE;
            rng_ticks = '0;
            w.done_res = 1'b1;
            w.status   = ST_NO_RISE;
          end else begin
            w.busy_res = 1'b1;
          end
        end
      end
      PH_MEASURE: begin
        rng_pulse = rng_pulse + 1'b1;
        if (!echo) begin
          rng_phase    = PH_IDLE;
          rng_ticks    = '0;
          w.done_res   = 1'b1;
          w.echo_ticks = rng_pulse;
          if (rng_pulse < cfg_min_pulse || rng_pulse > cfg_max_pulse) begin
            w.status = ST_OUT_RANGE;
          end else begin
            w.status  = ST_OK;
            w.dist_mm = DIST_W'((int'(rng_pulse) * DIST_STEP + DIST_ROUND) / DIST_DEN);
          end
        end else if (rng_pulse >= cfg_fall_to) begin
          rng_phase    = PH_IDLE;
          rng_ticks    = '0;
          w.done_res   = 1'b1;
          w.status     = ST_STUCK;
          w.echo_ticks = rng_pulse;
        end else begin
          w.busy_res = 1'b1;
        end
      end
      default: begin
        rng_phase = PH_IDLE;
        if (start) begin
          rng_phase  = PH_PRE_LOW;
          rng_ticks  = COUNT_WIDTH'(1);
          rng_pulse  = '0;
          w.busy_res = 1'b1;
        end
      end
    endcase
    return w;
  endfunction

  // Checks result words, applies register writes and predicts each accepted tick.
  always @(posedge clk) begin
    res_t want;
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        if (pending_words.size() == 0) begin
          $error("result word with no expectation waiting");
          fail_count++;
        end else begin
          want = pending_words.pop_front();
          if (res_ch.trig_level !== want.trig_level) begin
            $error("trig_level: expected %0d, actual %0d", want.trig_level, res_ch.trig_level);
            fail_count++;
          end
          if (res_ch.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0d, actual %0d", want.busy_res, res_ch.busy_res);
            fail_count++;
          end
          if (res_ch.done_res !== want.done_res) begin
            $error("done_res: expected %0d, actual %0d", want.done_res, res_ch.done_res);
            fail_count++;
          end
          if (res_ch.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, res_ch.status);
            fail_count++;
          end
          if (res_ch.echo_ticks !== want.echo_ticks) begin
            $error("echo_ticks: expected %0d, actual %0d", want.echo_ticks,
                   res_ch.echo_ticks);
            fail_count++;
          end
          if (res_ch.dist_mm !== want.dist_mm) begin
            $error("dist_mm: expected %0d, actual %0d", want.dist_mm, res_ch.dist_mm);
            fail_count++;
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_RISE_TIMEOUT: cfg_rise_to   = cfg_ch.data;
          REG_FALL_TIMEOUT: cfg_fall_to   = cfg_ch.data;
          REG_MIN_PULSE:    cfg_min_pulse = cfg_ch.data;
          REG_MAX_PULSE:    cfg_max_pulse = cfg_ch.data;
          default: ;
        endcase
      end
      if (tick_ch.valid && tick_ch.ready) begin
        pending_words.push_back(next_ranger_word(tick_ch.start_req, tick_ch.echo_level));
      end
      if ((res_ch.valid && res_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
          (tick_ch.valid && tick_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
  end

  // Watchdog: too long without any word moving on any channel.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold-off when asked.
  initial begin
    int  burst;
    int  hold_left;
    bit  hold_seen;
    logic rdy;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_seen) hold_left = HOLD_CYCLES;
      hold_seen = hold_req;
      rdy = 1'b1;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (burst > 0) begin
        burst--;
        rdy = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 3) - 1;
        rdy   = 1'b0;
      end
      res_ch.ready <= rdy;
    end
  end

  // Offers one tick word and returns on the edge that accepts it; valid stays high.
  task automatic send_tick(input logic start, input logic echo);
    if (!calm && $urandom_range(0, 5) == 0) begin
      tick_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    tick_ch.valid      <= 1'b1;
    tick_ch.start_req  <= start;
    tick_ch.echo_level <= echo;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Waits until every predicted word has come back.
  task automatic wait_results();
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // Brings the ranger back to idle with short echo pulses and empties the result stream.
  task automatic settle();
    tick_ch.valid <= 1'b0;
    wait_results();
    while (rng_phase != PH_IDLE) begin
      send_tick(1'b0, rng_phase == PH_WAIT_RISE);
      tick_ch.valid <= 1'b0;
      wait_results();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Writes all four registers and one unused index while the ranger is idle.
  task automatic set_config(input logic [CFG_W-1:0] rise, input logic [CFG_W-1:0] fall,
                            input logic [CFG_W-1:0] min_p, input logic [CFG_W-1:0] max_p);
    settle();
    cfg_write(REG_RISE_TIMEOUT, rise);
    cfg_write(REG_FALL_TIMEOUT, fall);
    cfg_write(REG_MIN_PULSE, min_p);
    cfg_write(REG_MAX_PULSE, max_p);
    cfg_write(CFG_IDX_W'($urandom_range(FIRST_UNUSED_REG, LAST_REG_INDEX)), CFG_W'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  // One measurement: start, trigger ticks, echo low for wait_ticks, then an echo pulse
  // of pulse_len ticks counted from the rise (none when pulse_len is 0).
  task automatic run_ranging(input int wait_ticks, input int pulse_len, input bit noisy);
    send_tick(1'b1, 1'($urandom));
    repeat (TRIGGER_TICKS - 1) send_tick(noisy & 1'($urandom), 1'($urandom));
    repeat (wait_ticks) send_tick(noisy & 1'($urandom), 1'b0);
    if (pulse_len > 0) begin
      repeat (pulse_len) send_tick(noisy & 1'($urandom), 1'b1);
      send_tick(noisy & 1'($urandom), 1'b0);
    end
  endtask

  // Register values after reset: one good pulse and one too short.
  task automatic test_reset_defaults();
    settle();
    run_ranging(0, 150, 1'b1);
    run_ranging(3, 50, 1'b0);
  endtask

  // Good pulses, with start requests while busy and on the finishing tick.
  task automatic test_good_echo();
    set_config(CFG_W'(5), CFG_W'(20), CFG_W'(0), CFG_W'(65535));
    run_ranging(2, 3, 1'b1);
    run_ranging(0, 1, 1'b0);
  endtask

  // Echo never rises, including a zero rise timeout.
  task automatic test_no_rise();
    set_config(CFG_W'(1), CFG_W'(20), CFG_W'(0), CFG_W'(65535));
    run_ranging(3, 0, 1'b0);
    set_config(CFG_W'(0), CFG_W'(20), CFG_W'(0), CFG_W'(65535));
    run_ranging(2, 0, 1'b0);
  endtask

  // Echo stays high, including a zero fall timeout and a fall on the timeout tick.
  task automatic test_stuck_high();
    set_config(CFG_W'(10), CFG_W'(1), CFG_W'(0), CFG_W'(65535));
    run_ranging(0, 5, 1'b0);
    set_config(CFG_W'(10), CFG_W'(0), CFG_W'(0), CFG_W'(65535));
    run_ranging(1, 4, 1'b0);
    run_ranging(1, 1, 1'b0);
  endtask

  // Pulse range limits, and a minimum above the maximum.
  task automatic test_pulse_range();
    set_config(CFG_W'(10), CFG_W'(30), CFG_W'(5), CFG_W'(3));
    run_ranging(1, 4, 1'b0);
    set_config(CFG_W'(10), CFG_W'(30), CFG_W'(4), CFG_W'(6));
    run_ranging(0, 3, 1'b0);
    run_ranging(0, 4, 1'b0);
    run_ranging(0, 6, 1'b0);
    run_ranging(0, 7, 1'b0);
  endtask

  // Largest register values with a long pulse, and the widest empty window.
  task automatic test_full_scale();
    set_config(CFG_W'(65535), CFG_W'(65535), CFG_W'(0), CFG_W'(65535));
    run_ranging(0, 200, 1'b0);
    set_config(CFG_W'(20), CFG_W'(40), CFG_W'(65535), CFG_W'(0));
    run_ranging(1, 10, 1'b0);
  endtask

  // Result side held off long while ticks keep coming, so the input stalls.
  task automatic test_backpressure();
    set_config(CFG_W'(8), CFG_W'(20), CFG_W'(0), CFG_W'(65535));
    hold_req = 1'b1;
    run_ranging(2, 5, 1'b1);
    run_ranging(1, 3, 1'b0);
    hold_req = 1'b0;
  endtask

  // Random settings and measurements with random content, mixed with noise ticks.
  task automatic test_random_traffic(input int n_items);
    int unsigned first;
    bit          wide;
    first = items_sent;
    while (items_sent - first < n_items) begin
      wide = ($urandom_range(0, 7) == 0);
      if (wide) begin
        set_config(CFG_W'($urandom_range(1, 30)), CFG_W'($urandom_range(100, 400)),
                   CFG_W'($urandom_range(0, 100)), CFG_W'($urandom_range(150, 400)));
      end else if ($urandom_range(0, 5) == 0) begin
        set_config(CFG_W'($urandom_range(0, 20)), CFG_W'($urandom_range(0, 40)),
                   CFG_W'($urandom), CFG_W'($urandom));
      end else begin
        set_config(CFG_W'($urandom_range(0, 20)), CFG_W'($urandom_range(0, 40)),
                   CFG_W'($urandom_range(0, 30)), CFG_W'($urandom_range(0, 45)));
      end
      repeat (wide ? 1 : 6) begin
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 10)) send_tick(1'($urandom), 1'($urandom));
        end else if (wide) begin
          run_ranging($urandom_range(0, 35), $urandom_range(0, 450), 1'($urandom));
        end else begin
          run_ranging($urandom_range(0, 24), $urandom_range(0, 45), 1'($urandom));
        end
      end
    end
  endtask

  initial begin
    tick_ch.valid      = 1'b0;
    tick_ch.start_req  = 1'b0;
    tick_ch.echo_level = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_good_echo();
    test_no_rise();
    test_stuck_high();
    test_pulse_range();
    test_full_scale();
    test_backpressure();
    test_random_traffic(550);
    // Final stretch runs with both sides always willing.
    calm = 1'b1;
    test_random_traffic(200);

    tick_ch.valid <= 1'b0;
    wait_results();
    repeat (END_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
